/* hw/rtl/hrlp_pkg.sv */
// types, character constants and byte classifiers shared by the request line parser
package hrlp_pkg;

    // character codes
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_QM  = 8'h3F;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // token index codes
    localparam logic [1:0] TOK_METHOD  = 2'd0;
    localparam logic [1:0] TOK_PATH    = 2'd1;
    localparam logic [1:0] TOK_VERSION = 2'd2;
    localparam logic [1:0] TOK_MAX     = 2'd3;

    // results one input byte can cause
    localparam int MAX_ITEMS = 4;

    typedef enum logic [1:0] {
        PH_GAP,
        PH_TOKEN,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } esc_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] out_byte;
        logic [1:0] token_index;
        logic       line_ok;
    } res_item_t;

    // all results of one input byte, slot 0 first
    typedef struct packed {
        logic [2:0]                     n_items;
        res_item_t [MAX_ITEMS-1:0]      items;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] b);
        logic [3:0] nib;
        if (b <= 8'h39) begin
            nib = b[3:0];
        end else begin
            nib = b[3:0] + 4'd9;
        end
        return nib;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

    function automatic res_item_t mk_item(input logic st, input logic [7:0] byt,
                                          input logic [1:0] idx, input logic ok);
        res_item_t it;
        it.is_status   = st;
        it.out_byte    = byt;
        it.token_index = idx;
        it.line_ok     = ok;
        return it;
    endfunction

endpackage

/* hw/rtl/hrlp_front.sv */
// front end: tracks line, token and escape state and builds the result list of each byte
module hrlp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               q_full,
    output logic               push,
    output hrlp_pkg::entry_t   push_entry
);

    hrlp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       tok_reg, tok_next;
    logic             extra_reg, extra_next;
    logic             inq_reg, inq_next;
    hrlp_pkg::esc_t   esc_reg, esc_next;
    logic [7:0]       digit_reg, digit_next;

    logic             accept;
    hrlp_pkg::entry_t ent;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (ent.n_items != 3'd0);
    assign push_entry = ent;

    always_comb begin
        hrlp_pkg::esc_t fl1_esc;
        hrlp_pkg::esc_t fl2_esc;
        logic [7:0]     fl1_digit;
        logic [7:0]     fl2_digit;
        logic           main_vld;
        logic [7:0]     main_byte;
        logic [1:0]     main_idx;
        logic           end_line;
        logic           line_open;
        logic [2:0]     n;
        logic [7:0]     b;

        b          = s_tdata;
        phase_next = phase_reg;
        tok_next   = tok_reg;
        extra_next = extra_reg;
        inq_next   = inq_reg;
        esc_next   = esc_reg;
        digit_next = digit_reg;
        fl1_esc    = hrlp_pkg::ESC_NONE;
        fl2_esc    = hrlp_pkg::ESC_NONE;
        fl1_digit  = digit_reg;
        fl2_digit  = digit_reg;
        main_vld   = 1'b0;
        main_byte  = b;
        main_idx   = hrlp_pkg::TOK_METHOD;
        end_line   = 1'b0;
        ent        = '0;
        n          = 3'd0;

        line_open = (phase_reg == hrlp_pkg::PH_GAP) || (phase_reg == hrlp_pkg::PH_TOKEN);

        if (line_open) begin
            if (b == hrlp_pkg::CH_LF) begin
                end_line = 1'b1;
            end else if (hrlp_pkg::is_space(b)) begin
                if (phase_reg == hrlp_pkg::PH_TOKEN) begin
                    fl1_esc    = esc_reg;
                    esc_next   = hrlp_pkg::ESC_NONE;
                    phase_next = hrlp_pkg::PH_GAP;
                end
            end else begin
                if (phase_reg == hrlp_pkg::PH_GAP) begin
                    if (tok_reg != hrlp_pkg::TOK_MAX) begin
                        tok_next = tok_reg + 2'd1;
                    end else begin
                        extra_next = 1'b1;
                    end
                    inq_next   = 1'b0;
                    esc_next   = hrlp_pkg::ESC_NONE;
                    phase_next = hrlp_pkg::PH_TOKEN;
                end
                if (!extra_next && tok_next != 2'd0) begin
                    main_idx = tok_next - 2'd1;
                    if (main_idx == hrlp_pkg::TOK_PATH) begin
                        if (!inq_next) begin
                            if (b == hrlp_pkg::CH_QM) begin
                                fl1_esc  = esc_next;
                                esc_next = hrlp_pkg::ESC_NONE;
                                inq_next = 1'b1;
                            end else if (esc_next == hrlp_pkg::ESC_PCT && hrlp_pkg::is_hex(b)) begin
                                digit_next = b;
                                esc_next   = hrlp_pkg::ESC_DIGIT;
                            end else if (esc_next == hrlp_pkg::ESC_DIGIT
                                         && hrlp_pkg::is_hex(b)) begin
                                main_vld  = 1'b1;
                                main_byte = {hrlp_pkg::hex_nib(digit_reg), hrlp_pkg::hex_nib(b)};
                                esc_next  = hrlp_pkg::ESC_NONE;
                            end else begin
                                // broken or absent escape goes out literally first
                                fl1_esc = esc_next;
                                if (b == hrlp_pkg::CH_PCT) begin
                                    esc_next = hrlp_pkg::ESC_PCT;
                                end else begin
                                    esc_next = hrlp_pkg::ESC_NONE;
                                    main_vld = 1'b1;
                                end
                            end
                        end
                    end else begin
                        main_vld = 1'b1;
                    end
                end
            end
        end

        // the final byte closes a line that is still open
        if (s_tlast && line_open) begin
            end_line = 1'b1;
        end
        if (end_line) begin
            fl2_esc    = esc_next;
            fl2_digit  = digit_next;
            esc_next   = hrlp_pkg::ESC_NONE;
            phase_next = hrlp_pkg::PH_DONE;
        end

        // assemble results in order
        if (fl1_esc != hrlp_pkg::ESC_NONE) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b0, hrlp_pkg::CH_PCT,
                                                  hrlp_pkg::TOK_PATH, 1'b0);
            n = n + 3'd1;
        end
        if (fl1_esc == hrlp_pkg::ESC_DIGIT) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b0, fl1_digit, hrlp_pkg::TOK_PATH, 1'b0);
            n = n + 3'd1;
        end
        if (main_vld) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b0, main_byte, main_idx, 1'b0);
            n = n + 3'd1;
        end
        if (fl2_esc != hrlp_pkg::ESC_NONE) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b0, hrlp_pkg::CH_PCT,
                                                  hrlp_pkg::TOK_PATH, 1'b0);
            n = n + 3'd1;
        end
        if (fl2_esc == hrlp_pkg::ESC_DIGIT) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b0, fl2_digit, hrlp_pkg::TOK_PATH, 1'b0);
            n = n + 3'd1;
        end
        if (end_line) begin
            ent.items[n[1:0]] = hrlp_pkg::mk_item(1'b1, 8'h00, hrlp_pkg::TOK_METHOD,
                                (tok_next == hrlp_pkg::TOK_MAX) && !extra_next);
            n = n + 3'd1;
        end
        ent.n_items = n;

        // the final byte returns everything to the idle line state
        if (s_tlast) begin
            phase_next = hrlp_pkg::PH_GAP;
            tok_next   = 2'd0;
            extra_next = 1'b0;
            inq_next   = 1'b0;
            esc_next   = hrlp_pkg::ESC_NONE;
            digit_next = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hrlp_pkg::PH_GAP;
            tok_reg   <= 2'd0;
            extra_reg <= 1'b0;
            inq_reg   <= 1'b0;
            esc_reg   <= hrlp_pkg::ESC_NONE;
            digit_reg <= 8'h00;
        end else if (accept) begin
            phase_reg <= phase_next;
            tok_reg   <= tok_next;
            extra_reg <= extra_next;
            inq_reg   <= inq_next;
            esc_reg   <= esc_next;
            digit_reg <= digit_next;
        end
    end

`ifndef SYNTHESIS
    a_entry_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.n_items <= 3'(hrlp_pkg::MAX_ITEMS)))
        else $error("result list overflows entry");
`endif

endmodule

/* hw/rtl/hrlp_queue.sv */
// short register queue of result lists between front and back
module hrlp_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  hrlp_pkg::entry_t   push_entry,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output hrlp_pkg::entry_t   head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hrlp_pkg::entry_t store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/hrlp_back.sv */
// back end: walks each queued result list and drives the registered result stream
module hrlp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  hrlp_pkg::entry_t   head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // out_byte, token_index, line_ok, zero fill
    output logic               m_tuser,   // is_status
    output logic               m_tlast    // run_last
);

    logic [1:0]          sel_reg, sel_next;
    logic                vld_reg, vld_next;
    hrlp_pkg::res_item_t item_reg, item_next;
    logic                last_reg, last_next;
    logic                load;
    logic                at_end;

    assign load   = head_valid && (!vld_reg || m_tready);
    assign at_end = ({1'b0, sel_reg} + 3'd1) == head.n_items;
    assign pop    = load && at_end;

    always_comb begin
        sel_next  = sel_reg;
        item_next = item_reg;
        last_next = last_reg;
        vld_next  = vld_reg && !m_tready;
        if (load) begin
            item_next = head.items[sel_reg];
            last_next = at_end;
            vld_next  = 1'b1;
            sel_next  = at_end ? 2'd0 : sel_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {5'd0, item_reg.line_ok, item_reg.token_index, item_reg.out_byte};
    assign m_tuser  = item_reg.is_status;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (head.n_items != 3'd0) && ({1'b0, sel_reg} < head.n_items))
        else $error("slot pointer outside result list");
`endif

endmodule

/* hw/rtl/http_request_line_parser.sv */
// top level of the http request line parser with path percent decoding
//
//  channel | dir | tdata                      | tuser     | tlast
//  s_      | in  | [7:0] data_byte            | -         | end_of_request
//  m_      | out | [7:0] out_byte, [9:8]      | is_status | run_last
//          |     | token_index, [10] line_ok  |           |
//
//  one input byte is taken per cycle while the queue has room
//  a byte yields 0 to 4 results; the back end sends one result per cycle while m_tready
//  is high, and the queue absorbs short bursts
//  input to first output passes the queue register, then the output register
//  synchronous active-low reset returns to the start of a request, queue empty
//  a stalled output fills the queue, then s_tready drops; no state is lost
module http_request_line_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // end_of_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_byte, token_index, line_ok, zero fill
    output logic        m_tuser,    // is_status
    output logic        m_tlast     // run_last
);

    // front to queue
    logic             push;
    hrlp_pkg::entry_t push_entry;
    logic             q_full;

    // queue to back
    logic             pop;
    logic             head_valid;
    hrlp_pkg::entry_t head;

    // classify each byte and build its result list
    hrlp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples the byte side from output stalls
    hrlp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // serialize result lists onto the output stream
    hrlp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
